[design/erc_pkg.sv]
// Shared constants and status types for the extent run coalescer.
// No dependencies; used by erc_front, erc_back and the top level.
`default_nettype none

package erc_pkg;

	localparam int REGION_BITS = 32;
	localparam int OFFSET_BITS = 32;
	// run end = offset + length, kept one bit wider so it never wraps
	localparam int END_BITS = OFFSET_BITS + 1;

	localparam int IQ_DEPTH = 2;
	localparam int IQ_CNT_BITS = 2;
	localparam int IQ_PTR_BITS = 1;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_CNT_BITS = 3;
	localparam int OQ_PTR_BITS = 2;

	typedef struct packed {
		logic pending_valid;
		logic [OQ_CNT_BITS-1:0] out_count;
	} back_stat_t;

endpackage

`default_nettype wire

[design/erc_front.sv]
// Front end: accepts extent requests, precomputes the extent end offset and
// holds them in a two-entry queue for the back end. Uses erc_pkg.
`default_nettype none

module erc_front #(
	parameter int LEN_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [erc_pkg::REGION_BITS-1:0] region_id,
	input  wire logic [LEN_BITS-1:0]             extent_len,
	input  wire logic [erc_pkg::OFFSET_BITS-1:0] start_offset,
	input  wire logic                            last_in,
	output logic                                 q_valid,
	output logic [erc_pkg::REGION_BITS-1:0]      q_region,
	output logic [LEN_BITS-1:0]                  q_len,
	output logic [erc_pkg::OFFSET_BITS-1:0]      q_offset,
	output logic [erc_pkg::END_BITS-1:0]         q_end,
	output logic                                 q_last,
	input  wire logic                            q_pop
);

	typedef struct packed {
		logic [erc_pkg::REGION_BITS-1:0] region;
		logic [LEN_BITS-1:0]             len;
		logic [erc_pkg::OFFSET_BITS-1:0] offset;
		logic [erc_pkg::END_BITS-1:0]    run_end;
		logic                            last;
	} item_t;

	item_t                             entry_q [erc_pkg::IQ_DEPTH];
	item_t                             new_item;
	logic [erc_pkg::IQ_PTR_BITS-1:0]   wr_ptr_q;
	logic [erc_pkg::IQ_PTR_BITS-1:0]   rd_ptr_q;
	logic [erc_pkg::IQ_CNT_BITS-1:0]   count_q;
	logic                              push;

	assign in_ready = (count_q != erc_pkg::IQ_CNT_BITS'(erc_pkg::IQ_DEPTH));
	assign push     = in_valid && in_ready;

	always_comb begin
		new_item.region  = region_id;
		new_item.len     = extent_len;
		new_item.offset  = start_offset;
		new_item.run_end = {1'b0, start_offset} + erc_pkg::END_BITS'(extent_len);
		new_item.last    = last_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	assign q_valid  = (count_q != '0);
	assign q_region = entry_q[rd_ptr_q].region;
	assign q_len    = entry_q[rd_ptr_q].len;
	assign q_offset = entry_q[rd_ptr_q].offset;
	assign q_end    = entry_q[rd_ptr_q].run_end;
	assign q_last   = entry_q[rd_ptr_q].last;

endmodule

`default_nettype wire

[design/erc_back.sv]
// Back end: holds the pending run, merges or closes it against the queue
// head and pushes zero, one or two results into a four-entry output queue.
// Uses erc_pkg.
`default_nettype none

module erc_back #(
	parameter int LEN_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_valid,
	input  wire logic [erc_pkg::REGION_BITS-1:0] q_region,
	input  wire logic [LEN_BITS-1:0]             q_len,
	input  wire logic [erc_pkg::OFFSET_BITS-1:0] q_offset,
	input  wire logic [erc_pkg::END_BITS-1:0]    q_end,
	input  wire logic                            q_last,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [erc_pkg::REGION_BITS-1:0]      out_region,
	output logic [LEN_BITS-1:0]                  out_len,
	output logic [erc_pkg::OFFSET_BITS-1:0]      out_offset,
	output logic                                 out_last,
	output erc_pkg::back_stat_t                  stat
);

	typedef struct packed {
		logic [erc_pkg::REGION_BITS-1:0] region;
		logic [LEN_BITS-1:0]             len;
		logic [erc_pkg::OFFSET_BITS-1:0] offset;
		logic                            last;
	} result_t;

	logic                              pend_valid_q;
	logic [erc_pkg::REGION_BITS-1:0]   pend_region_q;
	logic [erc_pkg::OFFSET_BITS-1:0]   pend_offset_q;
	logic [LEN_BITS-1:0]               pend_len_q;
	logic [erc_pkg::END_BITS-1:0]      pend_end_q;

	result_t                           oq_q [erc_pkg::OQ_DEPTH];
	logic [erc_pkg::OQ_PTR_BITS-1:0]   oq_wr_q;
	logic [erc_pkg::OQ_PTR_BITS-1:0]   oq_rd_q;
	logic [erc_pkg::OQ_CNT_BITS-1:0]   oq_cnt_q;

	logic [LEN_BITS:0]                 len_sum;
	logic                              joins;
	logic                              emit_close;
	logic [1:0]                        need;
	logic [erc_pkg::OQ_CNT_BITS-1:0]   cnt_after;
	logic                              out_pop;
	result_t                           res_close;
	result_t                           res_final;
	result_t                           res_first;
	logic [1:0]                        n_push;

	assign len_sum = {1'b0, pend_len_q} + {1'b0, q_len};
	assign joins   = pend_valid_q && (pend_region_q == q_region)
		&& (pend_end_q == {1'b0, q_offset}) && !len_sum[LEN_BITS];
	assign emit_close = pend_valid_q && !joins;
	assign need       = {1'b0, emit_close} + {1'b0, q_last};
	assign cnt_after  = oq_cnt_q + erc_pkg::OQ_CNT_BITS'(need);
	// only the present fill counts; no credit for a same-cycle drain
	assign q_pop      = q_valid
		&& (cnt_after <= erc_pkg::OQ_CNT_BITS'(erc_pkg::OQ_DEPTH));
	assign out_valid  = (oq_cnt_q != '0);
	assign out_pop    = out_valid && out_ready;
	assign n_push     = q_pop ? need : 2'd0;

	always_comb begin
		res_close.region = pend_region_q;
		res_close.len    = pend_len_q;
		res_close.offset = pend_offset_q;
		res_close.last   = 1'b0;
		if (joins) begin
			res_final.region = pend_region_q;
			res_final.len    = len_sum[LEN_BITS-1:0];
			res_final.offset = pend_offset_q;
		end else begin
			res_final.region = q_region;
			res_final.len    = q_len;
			res_final.offset = q_offset;
		end
		res_final.last = 1'b1;
		res_first = emit_close ? res_close : res_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q  <= 1'b0;
			pend_region_q <= '0;
			pend_offset_q <= '0;
			pend_len_q    <= '0;
			pend_end_q    <= '0;
			oq_wr_q       <= '0;
			oq_rd_q       <= '0;
			oq_cnt_q      <= '0;
		end else begin
			if (q_pop) begin
				if (q_last) begin
					pend_valid_q  <= 1'b0;
					pend_region_q <= '0;
					pend_offset_q <= '0;
					pend_len_q    <= '0;
					pend_end_q    <= '0;
				end else if (joins) begin
					pend_len_q <= len_sum[LEN_BITS-1:0];
					// joined extent starts at the run end, so its end is the new one
					pend_end_q <= q_end;
				end else begin
					pend_valid_q  <= 1'b1;
					pend_region_q <= q_region;
					pend_offset_q <= q_offset;
					pend_len_q    <= q_len;
					pend_end_q    <= q_end;
				end
			end
			oq_wr_q  <= oq_wr_q + erc_pkg::OQ_PTR_BITS'(n_push);
			if (out_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			oq_cnt_q <= oq_cnt_q + erc_pkg::OQ_CNT_BITS'(n_push)
				- erc_pkg::OQ_CNT_BITS'(out_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			oq_q[oq_wr_q] <= res_first;
		end
		if (n_push == 2'd2) begin
			oq_q[oq_wr_q + 1'b1] <= res_final;
		end
	end

	assign out_region = oq_q[oq_rd_q].region;
	assign out_len    = oq_q[oq_rd_q].len;
	assign out_offset = oq_q[oq_rd_q].offset;
	assign out_last   = oq_q[oq_rd_q].last;

	assign stat.pending_valid = pend_valid_q;
	assign stat.out_count     = oq_cnt_q;

endmodule

`default_nettype wire

[design/extent_run_coalescer_top.sv]
// Top level of the extent run coalescer: front queue plus merge back end.
// Depends on erc_pkg, erc_front and erc_back.
`default_nettype none

// Extent run coalescer. Extent requests (region, length, offset, last) are
// accepted at one per cycle into a two-entry queue; the back end takes one
// queue entry per cycle, merging it into the pending run when it is in the
// same region, starts at the run end and the summed length fits in LEN_BITS,
// and otherwise emitting the pending run. The last extent of a list flushes
// the run with out_last set, so one request yields zero, one or two results.
// Sustained rate is one extent per cycle; the back end holds an entry only
// while the four-entry output queue lacks room for the results it makes.
// Each extent is held in the front queue, its results in the output queue.
module extent_run_coalescer_top #(
	parameter int LEN_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [erc_pkg::REGION_BITS-1:0] region_id,
	input  wire logic [LEN_BITS-1:0]             extent_len,
	input  wire logic [erc_pkg::OFFSET_BITS-1:0] start_offset,
	input  wire logic                            last_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [erc_pkg::REGION_BITS-1:0]      out_region,
	output logic [LEN_BITS-1:0]                  out_len,
	output logic [erc_pkg::OFFSET_BITS-1:0]      out_offset,
	output logic                                 out_last
);

	logic                              q_valid;
	logic [erc_pkg::REGION_BITS-1:0]   q_region;
	logic [LEN_BITS-1:0]               q_len;
	logic [erc_pkg::OFFSET_BITS-1:0]   q_offset;
	logic [erc_pkg::END_BITS-1:0]      q_end;
	logic                              q_last;
	logic                              q_pop;
	erc_pkg::back_stat_t               stat;

	erc_front #(.LEN_BITS(LEN_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.region_id    (region_id),
		.extent_len   (extent_len),
		.start_offset (start_offset),
		.last_in      (last_in),
		.q_valid      (q_valid),
		.q_region     (q_region),
		.q_len        (q_len),
		.q_offset     (q_offset),
		.q_end        (q_end),
		.q_last       (q_last),
		.q_pop        (q_pop)
	);

	erc_back #(.LEN_BITS(LEN_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_region   (q_region),
		.q_len      (q_len),
		.q_offset   (q_offset),
		.q_end      (q_end),
		.q_last     (q_last),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_region (out_region),
		.out_len    (out_len),
		.out_offset (out_offset),
		.out_last   (out_last),
		.stat       (stat)
	);

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped an empty queue");

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.out_count <= erc_pkg::OQ_CNT_BITS'(erc_pkg::OQ_DEPTH))
		else $error("output queue overfilled");

	a_last_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_last) |=> !stat.pending_valid)
		else $error("run still pending after last extent");

	a_pop_sets_run: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_last) |=> stat.pending_valid)
		else $error("no pending run after a non-last extent");

endmodule

`default_nettype wire
